@@ sv/ept_pkg.sv @@
`timescale 1ns / 1ps
package ept_pkg;

    // fixed field widths
    localparam int OUT_W      = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int ALPHA_W    = 16;
    localparam int THR_W      = 16;
    localparam int GAP_W      = 24;
    localparam int RATE_W     = 18;
    localparam int DIV_W      = 8;
    localparam int FRAC_W     = 16;
    // rate * 60 * 256 always fits in 32 bits
    localparam int SCALE_W    = 32;
    localparam int QCNT_W     = 5;

    localparam logic [OUT_W-1:0]  TEMPO_CAP  = '1;
    localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_MODE    = 3'd0,
        CFG_SMOOTHING_ALPHA = 3'd1,
        CFG_PEAK_THRESHOLD  = 3'd2,
        CFG_MIN_GAP         = 3'd3,
        CFG_SAMPLE_RATE     = 3'd4,
        CFG_TEMPO_DIVISOR   = 3'd5
    } t_cfg_idx;

    localparam logic               RST_CHANNEL_MODE = 1'b1;
    localparam logic [ALPHA_W-1:0] RST_ALPHA        = 16'd6554;
    localparam logic [THR_W-1:0]   RST_THRESHOLD    = 16'd1638;
    localparam logic [GAP_W-1:0]   RST_MIN_GAP      = 24'd500;
    localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE  = 18'd44100;
    localparam logic [DIV_W-1:0]   RST_DIVISOR      = 8'd35;

    typedef struct packed {
        logic capture;
        logic mul;
        logic eval;
        logic put_peak;
        logic t_prep;
        logic t_mul_lo;
        logic t_mul_hi;
        logic t_sum;
        logic t_sat;
        logic t_div;
        logic put_tempo;
    } t_ept_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
        logic div_done;
    } t_ept_status;

endpackage

@@ sv/ept_in_if.sv @@
`timescale 1ns / 1ps
interface ept_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_left;
    logic signed [SAMPLE_WIDTH-1:0] sample_right;
    logic                           last;

    modport source (output valid, output sample_left, output sample_right, output last,
                    input ready);
    modport sink   (input valid, input sample_left, input sample_right, input last,
                    output ready);
endinterface

@@ sv/ept_out_if.sv @@
`timescale 1ns / 1ps
interface ept_out_if import ept_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             peak_found;
    logic [OUT_W-1:0] peak_position;
    logic             tempo_valid;
    logic [OUT_W-1:0] tempo_q8;

    modport source (output valid, output peak_found, output peak_position,
                    output tempo_valid, output tempo_q8, input ready);
    modport sink   (input valid, input peak_found, input peak_position,
                    input tempo_valid, input tempo_q8, output ready);
endinterface

@@ sv/ept_ctrl.sv @@
`timescale 1ns / 1ps
module ept_ctrl import ept_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_ept_status i_status,
    output t_ept_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_MUL     = 10'b00_0000_0010,
        S_EVAL    = 10'b00_0000_0100,
        S_TPREP   = 10'b00_0000_1000,
        S_TMUL_LO = 10'b00_0001_0000,
        S_TMUL_HI = 10'b00_0010_0000,
        S_TSUM    = 10'b00_0100_0000,
        S_TSAT    = 10'b00_1000_0000,
        S_TDIV    = 10'b01_0000_0000,
        S_TOUT    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                // last frame: judge the pending sample, then run the tempo math
                if (i_status.last) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_TPREP;
                end else if (i_status.out_free) begin
                    o_cmd.eval     = 1'b1;
                    o_cmd.put_peak = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TPREP: begin
                o_cmd.t_prep = 1'b1;
                n_state      = S_TMUL_LO;
            end
            S_TMUL_LO: begin
                o_cmd.t_mul_lo = 1'b1;
                n_state        = S_TMUL_HI;
            end
            S_TMUL_HI: begin
                o_cmd.t_mul_hi = 1'b1;
                n_state        = S_TSUM;
            end
            S_TSUM: begin
                o_cmd.t_sum = 1'b1;
                n_state     = S_TSAT;
            end
            S_TSAT: begin
                o_cmd.t_sat = 1'b1;
                n_state     = S_TDIV;
            end
            S_TDIV: begin
                o_cmd.t_div = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_TOUT;
                end
            end
            S_TOUT: begin
                if (i_status.out_free) begin
                    o_cmd.put_tempo = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ept_datapath.sv @@
`timescale 1ns / 1ps
module ept_datapath import ept_pkg::*; #(
    parameter int COUNT_WIDTH  = 24,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_wdata,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_left,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_right,
    input  logic                           i_last,
    input  t_ept_cmd                       i_cmd,
    output t_ept_status                    o_status,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_peak_found,
    output logic [OUT_W-1:0]               o_peak_position,
    output logic                           o_tempo_valid,
    output logic [OUT_W-1:0]               o_tempo_q8
);

    localparam int EW   = SAMPLE_WIDTH + FRAC_W;
    localparam int DFW  = EW + 1;
    localparam int PW   = EW + 18;
    localparam int TW   = (EW > THR_W + FRAC_W) ? EW : THR_W + FRAC_W;
    localparam int GW   = (COUNT_WIDTH > GAP_W) ? COUNT_WIDTH : GAP_W;
    localparam int BLO  = (COUNT_WIDTH + 1) / 2;
    localparam int BHI  = COUNT_WIDTH - BLO;
    localparam int PLW  = SCALE_W + BLO;
    localparam int PHW  = SCALE_W + BHI;
    localparam int DW   = COUNT_WIDTH + DIV_W;
    localparam int NW   = SCALE_W + COUNT_WIDTH;
    localparam int QW   = OUT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // configuration
    logic               r_channel_mode;
    logic [ALPHA_W-1:0] r_alpha;
    logic [THR_W-1:0]   r_threshold;
    logic [GAP_W-1:0]   r_min_gap;
    logic [RATE_W-1:0]  r_rate;
    logic [DIV_W-1:0]   r_divisor;

    // stream state
    logic [EW-1:0]          r_env_before;
    logic [EW-1:0]          r_env_mid;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] r_peak_total;
    logic [COUNT_WIDTH-1:0] r_first;
    logic [COUNT_WIDTH-1:0] r_latest;

    // per-item working registers
    logic [EW-1:0]          r_x;
    logic signed [DFW-1:0]  r_diff;
    logic                   r_last;
    logic signed [PW-1:0]   r_prod;
    logic                   r_found;
    logic [OUT_W-1:0]       r_pos;

    // tempo working registers
    logic [SCALE_W-1:0]     r_scale;
    logic [DW-1:0]          r_den;
    logic                   r_few;
    logic [COUNT_WIDTH-1:0] r_b;
    logic [PLW-1:0]         r_plo;
    logic [PHW-1:0]         r_phi;
    logic [NW-1:0]          r_rem;
    logic [NW-1:0]          r_dsh;
    logic                   r_sat;
    logic [QW-1:0]          r_q;
    logic [QCNT_W-1:0]      r_qcnt;

    // output word
    logic                   r_ov;

    logic [SAMPLE_WIDTH:0]  w_sum;
    logic [SAMPLE_WIDTH:0]  w_mag;
    logic [EW-1:0]          w_x;
    logic signed [DFW-1:0]  w_diff;
    logic signed [PW-1:0]   w_env_sum;
    logic [EW-1:0]          w_env;
    logic [COUNT_WIDTH-1:0] w_idx;
    logic [COUNT_WIDTH-1:0] w_gap;
    logic                   w_is_peak;
    logic                   w_out_free;
    logic                   w_ge;

    // rectify: left alone, or left + right at half-sample precision
    always_comb begin
        if (r_channel_mode) begin
            w_sum = {i_sample_left[SAMPLE_WIDTH-1], i_sample_left}
                  + {i_sample_right[SAMPLE_WIDTH-1], i_sample_right};
        end else begin
            w_sum = {i_sample_left[SAMPLE_WIDTH-1], i_sample_left};
        end
        w_mag = w_sum[SAMPLE_WIDTH] ? (~w_sum + 1'b1) : w_sum;
        if (r_channel_mode) begin
            w_x = {w_mag, {(FRAC_W-1){1'b0}}};
        end else begin
            w_x = {w_mag[SAMPLE_WIDTH-1:0], {FRAC_W{1'b0}}};
        end
        w_diff = $signed({1'b0, w_x}) - $signed({1'b0, r_env_mid});
    end

    // env = prev + alpha*(x - prev), rounded half up; the first sample loads x directly
    always_comb begin
        w_env_sum = PW'($signed({1'b0, r_env_mid, {FRAC_W{1'b0}}})) + r_prod
                  + PW'($signed({1'b0, ROUND_HALF}));
        if (r_count == '0) begin
            w_env = r_x;
        end else begin
            w_env = w_env_sum[EW+FRAC_W-1:FRAC_W];
        end
    end

    // judge the middle sample against its neighbors
    always_comb begin
        w_idx     = r_count - 1'b1;
        w_gap     = w_idx - r_latest;
        w_is_peak = (r_count >= COUNT_WIDTH'(2))
                 && (r_env_mid > r_env_before)
                 && (r_env_mid > w_env)
                 && (TW'(r_env_mid) > TW'({r_threshold, {FRAC_W{1'b0}}}))
                 && ((r_peak_total == '0) || (GW'(w_gap) > GW'(r_min_gap)));
    end

    assign w_out_free = !r_ov || i_out_ready;
    assign w_ge       = (r_rem >= r_dsh);

    assign o_status.last     = r_last;
    assign o_status.out_free = w_out_free;
    assign o_status.div_done = (r_qcnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_mode <= RST_CHANNEL_MODE;
            r_alpha        <= RST_ALPHA;
            r_threshold    <= RST_THRESHOLD;
            r_min_gap      <= RST_MIN_GAP;
            r_rate         <= RST_SAMPLE_RATE;
            r_divisor      <= RST_DIVISOR;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CHANNEL_MODE:    r_channel_mode <= i_cfg_wdata[0];
                CFG_SMOOTHING_ALPHA: r_alpha        <= i_cfg_wdata[ALPHA_W-1:0];
                CFG_PEAK_THRESHOLD:  r_threshold    <= i_cfg_wdata[THR_W-1:0];
                CFG_MIN_GAP:         r_min_gap      <= i_cfg_wdata[GAP_W-1:0];
                CFG_SAMPLE_RATE:     r_rate         <= i_cfg_wdata[RATE_W-1:0];
                CFG_TEMPO_DIVISOR:   r_divisor      <= i_cfg_wdata[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_before <= '0;
            r_env_mid    <= '0;
            r_count      <= '0;
            r_peak_total <= '0;
            r_first      <= '0;
            r_latest     <= '0;
        end else if (i_cmd.eval) begin
            r_env_before <= r_env_mid;
            r_env_mid    <= w_env;
            if (r_count != COUNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
            if (w_is_peak) begin
                if (r_peak_total == '0) begin
                    r_first <= w_idx;
                end
                r_latest <= w_idx;
                if (r_peak_total != COUNT_MAX) begin
                    r_peak_total <= r_peak_total + 1'b1;
                end
            end
        end else if (i_cmd.put_tempo) begin
            // end of stream: start the next one clean
            r_env_before <= '0;
            r_env_mid    <= '0;
            r_count      <= '0;
            r_peak_total <= '0;
            r_first      <= '0;
            r_latest     <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x    <= w_x;
            r_diff <= w_diff;
            r_last <= i_last;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'($signed({1'b0, r_alpha})) * PW'(r_diff);
        end
        if (i_cmd.eval) begin
            r_found <= w_is_peak;
            r_pos   <= w_is_peak ? OUT_W'(w_idx) : '0;
        end
    end

    // tempo = rate*15360*(peaks-1) / ((latest-first)*divisor), restoring divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.t_prep) begin
            r_scale <= {r_rate, 14'b0} - {4'b0, r_rate, 10'b0};
            r_den   <= DW'(r_latest - r_first) * DW'(r_divisor);
            r_few   <= (r_peak_total < COUNT_WIDTH'(2));
            r_b     <= r_peak_total - 1'b1;
        end
        if (i_cmd.t_mul_lo) begin
            r_plo <= PLW'(r_scale) * PLW'(r_b[BLO-1:0]);
        end
        if (i_cmd.t_mul_hi) begin
            r_phi <= PHW'(r_scale) * PHW'(r_b[COUNT_WIDTH-1:BLO]);
        end
        if (i_cmd.t_sum) begin
            r_rem <= NW'(r_plo) + (NW'(r_phi) << BLO);
        end
        if (i_cmd.t_sat) begin
            r_sat  <= (r_den == '0) || (r_rem >= {r_den, {QW{1'b0}}});
            r_dsh  <= NW'({r_den, {(QW-1){1'b0}}});
            r_q    <= '0;
            r_qcnt <= QCNT_W'(QW - 1);
        end
        if (i_cmd.t_div) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q    <= {r_q[QW-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
            r_qcnt <= r_qcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.put_peak || i_cmd.put_tempo) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_peak) begin
            o_peak_found    <= w_is_peak;
            o_peak_position <= w_is_peak ? OUT_W'(w_idx) : '0;
            o_tempo_valid   <= 1'b0;
            o_tempo_q8      <= '0;
        end else if (i_cmd.put_tempo) begin
            o_peak_found    <= r_found;
            o_peak_position <= r_pos;
            o_tempo_valid   <= 1'b1;
            o_tempo_q8      <= r_few ? '0 : (r_sat ? TEMPO_CAP : r_q);
        end
    end

    assign o_out_valid = r_ov;

`ifndef NO_ASSERTIONS
    a_put_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put_peak || i_cmd.put_tempo) |-> w_out_free)
        else $error("result written over a word still waiting");
    a_peaks_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak_total <= r_count)
        else $error("more peaks than samples");
    a_peak_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latest >= r_first)
        else $error("latest peak before first peak");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.t_div && !r_sat) |-> ({1'b0, r_rem} < {r_dsh, 1'b0}))
        else $error("divider remainder out of range");
`endif

endmodule

@@ sv/envelope_peak_tempo_estimator_core.sv @@
`timescale 1ns / 1ps
// Ordinary frame: capture, alpha multiply and peak judgment, then the result word is
//   registered; judgment waits for room in the output word, then the next frame is taken.
// Last frame: after the judgment come tempo prep, low and high products, sum, saturation
//   check and the divide, one quotient bit per cycle, then the word waits for room.
// Synchronous active-low reset loads the register defaults and clears the stream state;
//   the block is ready as soon as reset is released, with no clearing pass.
module envelope_peak_tempo_estimator_core import ept_pkg::*; #(
    parameter int COUNT_WIDTH  = 24,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    ept_in_if.sink                i_in,
    ept_out_if.source             o_out
);

    t_ept_cmd    w_cmd;
    t_ept_status w_status;

    // Sequencer: accept a frame, multiply, judge the middle sample; on the last
    // frame continue through the tempo products and the divide before the word.
    ept_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: registers, envelope filter, peak picker, tempo divider and the
    // output word register. The output register lets a new frame be accepted
    // while the previous word still waits downstream.
    ept_datapath #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_sample_left   (i_in.sample_left),
        .i_sample_right  (i_in.sample_right),
        .i_last          (i_in.last),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_peak_found    (o_out.peak_found),
        .o_peak_position (o_out.peak_position),
        .o_tempo_valid   (o_out.tempo_valid),
        .o_tempo_q8      (o_out.tempo_q8)
    );

endmodule
